>>> rtl/tsfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsfs_pkg
// Byte codes, widths and reset values for the text / STX frame splitter.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned OvhW   = 4;
  localparam int unsigned FrameW = 9;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [OvhW-1:0]   ovh_t;
  typedef logic [FrameW-1:0] frame_cnt_t;

  localparam byte_t ChNewline = 8'h0A;
  localparam byte_t ChAck     = 8'h06;
  localparam byte_t ChNack    = 8'h15;
  localparam byte_t ChStx     = 8'h02;

  localparam ovh_t       OverheadReset = 4'd5;
  localparam frame_cnt_t FrameMinTotal = 9'd2;

endpackage : tsfs_pkg
`default_nettype wire

>>> rtl/text_and_stx_frame_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_and_stx_frame_splitter
// Splits a received serial byte stream into text segments and STX
// length-prefixed binary frames, tagging every byte with kind and marks.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------
//  in      | in  | in_valid_i / in_stall_o   | rx_byte_i
//  out     | out | out_valid_o / out_stall_i | out_byte_o, segment_kind_o,
//          |     |                           | segment_first_o, segment_last_o,
//          |     |                           | text_cut_o
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (frame_overhead)
//
//  One byte per cycle sustained while the output is not stalled; each accepted
//  byte shows up at the output register in the next cycle. The framing state and
//  the tagging logic sit between the input port and the single output register.
//  Reset (rst_ni low, asynchronous) returns to text mode with no open text
//  segment and frame_overhead = 5.
//  in_stall_o is high only while the output register holds a transaction
//  that the downstream side is stalling.
//  cfg_ready_o is always high; writes are expected only while idle.
//
module text_and_stx_frame_splitter
  import tsfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [OvhW-1:0]   cfg_data_i,

  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ByteW-1:0]  rx_byte_i,

  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ByteW-1:0]       out_byte_o,
  output logic                   segment_kind_o,
  output logic                   segment_first_o,
  output logic                   segment_last_o,
  output logic                   text_cut_o
);

  // configuration
  ovh_t ovh_q;

  // framing state
  logic       in_frame_q, in_frame_d;
  logic       text_open_q, text_open_d;
  frame_cnt_t pos_q, pos_d;
  frame_cnt_t total_q, total_d;

  // output register
  logic  out_valid_q, out_valid_d;
  byte_t out_byte_q;
  logic  kind_q, first_q, last_q, cut_q;
  logic  kind_d, first_d, last_d, cut_d;

  logic       accept;
  frame_cnt_t len_sum;
  frame_cnt_t len_total;
  frame_cnt_t total_sel;
  logic [FrameW:0] pos_next;

  assign cfg_ready_o = 1'b1;

  // The output register frees up when its transaction leaves this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Length byte plus overhead, saturated so the frame is at least STX+L.
  assign len_sum   = {1'b0, rx_byte_i} + {{(FrameW-OvhW){1'b0}}, ovh_q};
  assign len_total = (len_sum < FrameMinTotal) ? FrameMinTotal : len_sum;
  assign total_sel = (pos_q == frame_cnt_t'(1)) ? len_total : total_q;
  assign pos_next  = {1'b0, pos_q} + {{FrameW{1'b0}}, 1'b1};

  always_comb begin
    in_frame_d  = in_frame_q;
    text_open_d = text_open_q;
    pos_d       = pos_q;
    total_d     = total_q;
    kind_d      = 1'b0;
    first_d     = 1'b0;
    last_d      = 1'b0;
    cut_d       = 1'b0;
    if (in_frame_q) begin
      // Every frame byte is data; only the count ends the frame.
      kind_d  = 1'b1;
      total_d = total_sel;
      if (pos_next >= {1'b0, total_sel}) begin
        last_d     = 1'b1;
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else begin
        pos_d = pos_next[FrameW-1:0];
      end
    end else if (rx_byte_i == ChStx) begin
      // STX closes any open text segment without a last mark of its own.
      kind_d      = 1'b1;
      first_d     = 1'b1;
      cut_d       = text_open_q;
      text_open_d = 1'b0;
      in_frame_d  = 1'b1;
      pos_d       = frame_cnt_t'(1);
      total_d     = '0;
    end else begin
      first_d = !text_open_q;
      if (rx_byte_i inside {ChNewline, ChAck, ChNack}) begin
        last_d      = 1'b1;
        text_open_d = 1'b0;
      end else begin
        text_open_d = 1'b1;
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q       <= OverheadReset;
      in_frame_q  <= 1'b0;
      text_open_q <= 1'b0;
      pos_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ovh_q <= cfg_data_i;
      end
      if (accept) begin
        in_frame_q  <= in_frame_d;
        text_open_q <= text_open_d;
        pos_q       <= pos_d;
        total_q     <= total_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_byte_q <= rx_byte_i;
      kind_q     <= kind_d;
      first_q    <= first_d;
      last_q     <= last_d;
      cut_q      <= cut_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign segment_kind_o  = kind_q;
  assign segment_first_o = first_q;
  assign segment_last_o  = last_q;
  assign text_cut_o      = cut_q;

`ifndef ASSERT_OFF
  a_cut_on_stx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_cut_o |->
      segment_kind_o && segment_first_o && out_byte_o == ChStx)
    else $error("text cut flagged on a byte that is not a frame-opening STX");

  a_frame_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> pos_q != '0)
    else $error("frame position zero while inside a frame");

  a_stx_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_frame_q && rx_byte_i == ChStx |=>
      in_frame_q && pos_q == frame_cnt_t'(1))
    else $error("STX in text mode did not open a frame");

  a_text_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !segment_kind_o && segment_last_o |->
      (out_byte_o == ChNewline || out_byte_o == ChAck || out_byte_o == ChNack))
    else $error("text segment ended on a non-terminator byte");
`endif

endmodule : text_and_stx_frame_splitter
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text / STX frame splitter. A queue of received
// bytes feeds a clocked driver, and a clocked monitor checks every output
// transaction against a cycle-free model of the segment and frame tagging.
// The run covers several frame_overhead settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import tsfs_pkg::*;

  localparam int CycleLimit = 200_000;
  localparam int ErrShown   = 10;

  // one tagged output transaction
  typedef struct packed {
    byte_t data;
    logic  kind;
    logic  first;
    logic  last;
    logic  cut;
  } seg_tag_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  ovh_t        cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  byte_t       rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  byte_t       out_byte_o;
  logic        segment_kind_o;
  logic        segment_first_o;
  logic        segment_last_o;
  logic        text_cut_o;

  text_and_stx_frame_splitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .segment_kind_o  (segment_kind_o),
    .segment_first_o (segment_first_o),
    .segment_last_o  (segment_last_o),
    .text_cut_o      (text_cut_o)
  );

  // bench-side copy of the splitter state and of frame_overhead
  ovh_t       ovh_model;
  logic       fr_active;
  logic       txt_open;
  frame_cnt_t fr_pos;
  frame_cnt_t fr_total;

  byte_t    pending_bytes[$];   // bytes waiting for the driver
  seg_tag_t expected_tags[$];   // tags predicted for accepted bytes

  int  bytes_queued   = 0;
  int  bytes_taken    = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  in_fire        = 1'b0;   // input transaction at the last rising edge

  // --------------------------------------------------------------------------
  // Clock, cycle counter and run limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tagging model: one byte in, one tag out, state updated in place.
  // --------------------------------------------------------------------------
  function automatic seg_tag_t split_byte(byte_t b);
    seg_tag_t    t;
    int unsigned span;
    t = '{data: b, kind: 1'b0, first: 1'b0, last: 1'b0, cut: 1'b0};
    if (fr_active) begin
      // every frame byte is data, STX and control codes included
      t.kind = 1'b1;
      if (fr_pos == frame_cnt_t'(1)) begin
        // length byte: total = L + overhead, never below STX + length byte
        span = int'(b) + int'(ovh_model);
        if (span < FrameMinTotal) span = FrameMinTotal;
        fr_total = frame_cnt_t'(span);
      end
      if (int'(fr_pos) + 1 >= int'(fr_total)) begin
        t.last    = 1'b1;
        fr_active = 1'b0;
        fr_pos    = '0;
      end else begin
        fr_pos = fr_pos + 1'b1;
      end
    end else if (b == ChStx) begin
      // STX drops any open text segment without a last mark
      t.kind    = 1'b1;
      t.first   = 1'b1;
      t.cut     = txt_open;
      txt_open  = 1'b0;
      fr_active = 1'b1;
      fr_pos    = frame_cnt_t'(1);
      fr_total  = '0;
    end else begin
      t.first = !txt_open;
      if (b == ChNewline || b == ChAck || b == ChNack) begin
        t.last   = 1'b1;
        txt_open = 1'b0;
      end else begin
        txt_open = 1'b1;
      end
    end
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: new byte or idle at the falling edge, held while stalled.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check the output transaction first, then predict the input one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    seg_tag_t got;
    seg_tag_t want;
    if (rst_ni) begin
      in_fire = in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        got = '{data: out_byte_o, kind: segment_kind_o, first: segment_first_o,
                last: segment_last_o, cut: text_cut_o};
        if (expected_tags.size() == 0) begin
          mismatches++;
          if (mismatches <= ErrShown)
            $display("%0t: unexpected output byte=%h kind=%b first=%b last=%b cut=%b",
                     $realtime, got.data, got.kind, got.first, got.last, got.cut);
        end else begin
          want = expected_tags.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= ErrShown)
              $display({"%0t: tag error, exp byte=%h kind=%b first=%b last=%b cut=%b,",
                        " got byte=%h kind=%b first=%b last=%b cut=%b"},
                       $realtime, want.data, want.kind, want.first, want.last, want.cut,
                       got.data, got.kind, got.first, got.last, got.cut);
          end
        end
      end
      if (in_fire) begin
        expected_tags.push_back(split_byte(rx_byte_i));
        bytes_taken++;
      end
    end else begin
      in_fire = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(byte_t b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  function automatic byte_t terminator();
    case ($urandom_range(0, 2))
      0:       return ChNewline;
      1:       return ChAck;
      default: return ChNack;
    endcase
  endfunction

  // any byte that neither ends text nor opens a frame
  function automatic byte_t plain_byte();
    byte_t b;
    do b = byte_t'($urandom_range(0, 255));
    while (b == ChStx || b == ChNewline || b == ChAck || b == ChNack);
    return b;
  endfunction

  // frame payload, biased toward codes that would mean something in text mode
  function automatic byte_t frame_data();
    if ($urandom_range(0, 3) != 0) return byte_t'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return ChStx;
      1:       return ChNewline;
      2:       return ChAck;
      default: return ChNack;
    endcase
  endfunction

  task automatic queue_text(int n, bit closed);
    repeat (n) queue_byte(plain_byte());
    if (closed) queue_byte(terminator());
  endtask

  task automatic queue_frame(int len);
    int total;
    total = len + int'(ovh_model);
    if (total < 2) total = 2;
    queue_byte(ChStx);
    queue_byte(byte_t'(len));
    for (int i = 2; i < total; i++) queue_byte(frame_data());
  endtask

  // mostly well-formed lines and frames; unclosed lines get cut by the next
  // STX, and a little raw noise knocks the stream out of step now and then
  task automatic queue_traffic(int count);
    int start;
    int pick;
    start = bytes_queued;
    while (bytes_queued - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_text($urandom_range(0, 8), $urandom_range(0, 4) != 0);
      end else if (pick < 88) begin
        pick = $urandom_range(0, 99);
        if (pick < 90)      queue_frame($urandom_range(0, 12));
        else if (pick < 98) queue_frame($urandom_range(13, 60));
        else                queue_frame($urandom_range(61, 255));
      end else begin
        repeat ($urandom_range(1, 6)) queue_byte(byte_t'($urandom_range(0, 255)));
      end
    end
  endtask

  // idle = every queued byte accepted and every tag seen, plus drain time
  task automatic wait_idle();
    do @(negedge clk_i);
    while (bytes_taken != bytes_queued || expected_tags.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_overhead(ovh_t v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    ovh_model = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    out_stall_i = 1'b0;
    ovh_model   = OverheadReset;
    fr_active   = 1'b0;
    txt_open    = 1'b0;
    fr_pos      = '0;
    fr_total    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed, reset overhead of 5, no idling
    set_idling(0, 0);
    queue_byte(8'h41);       queue_byte(ChNewline);     // line with newline
    queue_byte(ChAck);                                  // lone ACK
    queue_byte(ChNack);                                 // lone NACK
    queue_byte(8'h00);       queue_byte(8'hFF);
    queue_byte(ChNewline);                              // byte extremes as text
    queue_byte(8'h78);       queue_byte(ChStx);         // STX cuts open text
    queue_byte(8'h00);                                  // L = 0, five bytes in all
    queue_byte(ChNewline);   queue_byte(ChStx);
    queue_byte(8'hFF);                                  // codes inside a frame
    queue_byte(ChStx);       queue_byte(8'h01);         // STX with no open text
    queue_byte(ChAck);       queue_byte(ChNack);
    queue_byte(ChStx);       queue_byte(8'h00);
    queue_byte(ChNewline);
    wait_idle();

    // Largest overhead, longest frame, sender mostly idle
    write_overhead(ovh_t'(15));
    set_idling(64, 0);
    queue_frame(255);
    queue_traffic(40);
    wait_idle();

    // Smallest legal overhead: two-byte frames, receiver stalling
    write_overhead(ovh_t'(2));
    set_idling(0, 64);
    queue_byte(ChStx);       queue_byte(8'h00);
    queue_byte(8'h41);       queue_byte(ChStx);
    queue_byte(8'h00);
    queue_traffic(50);
    wait_idle();

    // Overhead below range: total clamps at two bytes
    write_overhead(ovh_t'(0));
    set_idling(29, 29);
    queue_byte(ChStx);       queue_byte(8'h01);
    queue_byte(ChStx);       queue_byte(8'h00);
    queue_traffic(45);
    wait_idle();

    write_overhead(ovh_t'(1));
    set_idling(0, 0);
    queue_byte(ChStx);       queue_byte(8'h00);
    queue_byte(ChStx);       queue_byte(8'h01);
    queue_traffic(40);
    wait_idle();

    write_overhead(ovh_t'($urandom_range(3, 14)));
    set_idling(29, 29);
    queue_traffic(40);
    wait_idle();

    repeat (4) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
